// File: rtl/blal_pkg.sv
// ----------------------------------------------------------------------------
// blal_pkg: shared definitions for the bounded array list engine
// Field widths, request kinds, status codes and the default capacity.
// ----------------------------------------------------------------------------
package blal_pkg;

   // Default number of list entries
   localparam int CAPACITY_DEF = 16;

   // Payload field widths
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = 5;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_APPEND       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE_LAST  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVE_AT    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ         = 3'd5;
   localparam logic [KIND_W-1:0] KIND_FIND         = 3'd6;
   localparam logic [KIND_W-1:0] KIND_CLEAR        = 3'd7;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

// File: rtl/blal_channels.sv
// ----------------------------------------------------------------------------
// blal_channels: request and response channels of the list engine
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface blal_req_if;
   logic                               valid;
   logic                               ready;
   logic        [blal_pkg::KIND_W-1:0]  kind;
   logic signed [blal_pkg::VALUE_W-1:0] item_value;
   logic        [blal_pkg::SLOT_W-1:0]  slot;

   modport source (output valid, kind, item_value, slot, input ready);
   modport sink   (input valid, kind, item_value, slot, output ready);
endinterface

interface blal_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [blal_pkg::VALUE_W-1:0]  result_value;
   logic        [blal_pkg::SLOT_W-1:0]   result_slot;
   logic        [blal_pkg::STATUS_W-1:0] status;
   logic        [blal_pkg::ENTRY_W-1:0]  entry_count;

   modport source (output valid, result_value, result_slot, status, entry_count,
                   input ready);
   modport sink   (input valid, result_value, result_slot, status, entry_count,
                   output ready);
endinterface

// File: rtl/bounded_array_list_engine.sv
// Steps: clear and rejected requests go straight to S_DONE; append or insert at end:
// S_PUT; read: S_LOOK, S_TAKE; remove: S_LOOK, S_TAKE, S_RD, S_WR per entry moved;
// insert: S_RD, S_WR per entry moved, S_PUT; find: S_RD, S_CMP per entry compared.
// Throughput: one request at a time; the next beat is taken in the cycle the response
// goes valid, and a response still waiting holds the next request in its last step.
// Reset (synchronous): sequencer idle, list empty, response empty; memory not cleared.
// ----------------------------------------------------------------------------
// bounded_array_list_engine: fixed-capacity ordered list of signed words
// Append, insert, remove, read, find and clear, stepped through one memory
// by a small sequencer that moves or compares one entry at a time.
// ----------------------------------------------------------------------------
module bounded_array_list_engine #(
   parameter int CAPACITY = blal_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   blal_req_if.sink          req,
   blal_rsp_if.source        rsp
);
   import blal_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PUT  = 3'd1;
   localparam logic [2:0] S_LOOK = 3'd2;
   localparam logic [2:0] S_TAKE = 3'd3;
   localparam logic [2:0] S_RD   = 3'd4;
   localparam logic [2:0] S_WR   = 3'd5;
   localparam logic [2:0] S_CMP  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   // Entry memory
   logic signed [VALUE_W-1:0] mem [CAPACITY];
   logic signed [VALUE_W-1:0] rdata_ff;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ADDR_W-1:0]         rd_addr;
   logic signed [VALUE_W-1:0] wr_data;

   // Control and working registers
   logic [2:0]                state_ff, state_in;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [KIND_W-1:0]         kind_ff, kind_in;
   logic signed [VALUE_W-1:0] word_ff, word_in;
   logic [ADDR_W-1:0]         tgt_ff, tgt_in;
   logic [ADDR_W-1:0]         idx_ff, idx_in;
   logic signed [VALUE_W-1:0] rval_ff, rval_in;
   logic [SLOT_W-1:0]         rslot_ff, rslot_in;
   logic [STATUS_W-1:0]       status_ff, status_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0]        rsp_count_ff, rsp_count_in;

   logic                      req_beat;
   logic                      is_full;
   logic                      is_empty;
   logic [CMP_W-1:0]          occ_x;
   logic [CMP_W-1:0]          pos_x;
   logic [CNT_W-1:0]          idx_up;
   logic [CNT_W-1:0]          tgt_up;

   assign req.ready = (state_ff == S_IDLE);
   assign req_beat  = req.valid && req.ready;
   assign is_full   = (occ_ff == CNT_W'(CAPACITY));
   assign is_empty  = (occ_ff == '0);
   assign occ_x     = CMP_W'(occ_ff);
   assign pos_x     = CMP_W'(req.slot);
   assign idx_up    = CNT_W'(idx_ff) + CNT_W'(1);
   assign tgt_up    = CNT_W'(tgt_ff) + CNT_W'(1);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      occ_in    = occ_ff;
      kind_in   = kind_ff;
      word_in   = word_ff;
      tgt_in    = tgt_ff;
      idx_in    = idx_ff;
      rval_in   = rval_ff;
      rslot_in  = rslot_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = tgt_ff;
      wr_data   = word_ff;
      rd_addr   = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               kind_in   = req.kind;
               word_in   = req.item_value;
               rval_in   = '0;
               rslot_in  = '0;
               status_in = ST_OK;
               idx_in    = occ_ff[ADDR_W-1:0];
               state_in  = S_DONE;
               case (req.kind)
                  KIND_APPEND: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        tgt_in   = occ_ff[ADDR_W-1:0];
                        state_in = S_PUT;
                     end
                  end
                  KIND_INSERT: begin
                     tgt_in = ADDR_W'(req.slot);
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else if (pos_x > occ_x) begin
                        status_in = ST_BADPOS;
                     end else if (pos_x == occ_x) begin
                        state_in = S_PUT;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  KIND_REMOVE_LAST: begin
                     tgt_in = occ_ff[ADDR_W-1:0] - ADDR_W'(1);
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
                  KIND_REMOVE_FIRST: begin
                     tgt_in = '0;
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
                  KIND_REMOVE_AT: begin
                     tgt_in = ADDR_W'(req.slot);
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else if (pos_x >= occ_x) begin
                        status_in = ST_BADPOS;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
                  KIND_READ: begin
                     tgt_in = ADDR_W'(req.slot);
                     if (pos_x >= occ_x) begin
                        status_in = ST_BADPOS;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
                  KIND_FIND: begin
                     idx_in = '0;
                     if (is_empty) begin
                        status_in = ST_NOTFOUND;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     occ_in = '0;
                  end
               endcase
            end
         end

         // write the new word at its place
         S_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = tgt_ff;
            wr_data  = word_ff;
            occ_in   = occ_ff + CNT_W'(1);
            state_in = S_DONE;
         end

         // fetch the entry at the target
         S_LOOK: begin
            rd_addr  = tgt_ff;
            state_in = S_TAKE;
         end

         S_TAKE: begin
            rval_in = rdata_ff;
            idx_in  = tgt_ff + ADDR_W'(1);
            if (kind_ff == KIND_READ) begin
               state_in = S_DONE;
            end else if (tgt_up == occ_ff) begin
               occ_in   = occ_ff - CNT_W'(1);
               state_in = S_DONE;
            end else begin
               state_in = S_RD;
            end
         end

         // read one entry: the one below for insert, else the one at idx
         S_RD: begin
            rd_addr = (kind_ff == KIND_INSERT) ? (idx_ff - ADDR_W'(1)) : idx_ff;
            state_in = (kind_ff == KIND_FIND) ? S_CMP : S_WR;
         end

         // move one entry up (insert) or down (remove)
         S_WR: begin
            wr_en   = 1'b1;
            wr_data = rdata_ff;
            if (kind_ff == KIND_INSERT) begin
               wr_addr = idx_ff;
               idx_in  = idx_ff - ADDR_W'(1);
               state_in = ((idx_ff - ADDR_W'(1)) == tgt_ff) ? S_PUT : S_RD;
            end else begin
               wr_addr = idx_ff - ADDR_W'(1);
               idx_in  = idx_ff + ADDR_W'(1);
               if (idx_up == occ_ff) begin
                  occ_in   = occ_ff - CNT_W'(1);
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end

         // compare one entry against the search word
         S_CMP: begin
            idx_in = idx_ff + ADDR_W'(1);
            if (rdata_ff == word_ff) begin
               rslot_in = SLOT_W'(idx_ff);
               state_in = S_DONE;
            end else if (idx_up == occ_ff) begin
               status_in = ST_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               state_in = S_RD;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register: loaded from the finished request, held until taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp.ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = rval_ff;
         rsp_slot_in   = rslot_ff;
         rsp_status_in = status_ff;
         rsp_count_in  = ENTRY_W'(occ_ff);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      word_ff       <= word_in;
      tgt_ff        <= tgt_in;
      idx_ff        <= idx_in;
      rval_ff       <= rval_in;
      rslot_ff      <= rslot_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.result_slot  = rsp_slot_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.entry_count  = rsp_count_ff;

`ifndef NO_ASSERTIONS
   // occupancy never passes the capacity
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(CAPACITY))
      else $error("list occupancy above capacity");

   // occupancy moves by at most one per cycle, or drops to zero on clear
   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(occ_ff) |-> (occ_ff == $past(occ_ff) + CNT_W'(1)) ||
                           (occ_ff == $past(occ_ff) - CNT_W'(1)) ||
                           (occ_ff == '0))
      else $error("occupancy jumped");

   // a request beat makes the engine busy on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req.ready)
      else $error("engine ready right after a request beat");

   // memory is written only while a request is in progress
   a_wr_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_PUT || state_ff == S_WR))
      else $error("memory write outside a list update");
`endif

endmodule
